// File: src/accm_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and AES round functions for the CCM engine.
package accm_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [1:0] CFG_KEY_LOW  = 2'd1;
    localparam logic [1:0] CFG_TAG_LEN  = 2'd2;
    localparam logic [1:0] CFG_DECRYPT  = 2'd3;

    localparam logic [7:0] CTR_FLAGS   = 8'h07;
    localparam logic [7:0] ADATA_FLAG  = 8'h40;
    localparam logic [7:0] ADATA_LEN   = 8'd8;
    localparam logic [4:0] TAG_MIN     = 5'd4;
    localparam logic [4:0] TAG_MAX     = 5'd16;
    localparam logic [3:0] LAST_ROUND  = 4'd10;
    localparam logic [3:0] BLOCK_LAST  = 4'd15;

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_DATA  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        RK_DATA   = 2'd0,
        RK_TAG    = 2'd1,
        RK_STATUS = 2'd2
    } t_rkind;

    // One request as it waits in the queue
    typedef struct packed {
        t_kind       kind;
        logic [55:0] nonce;
        logic [15:0] msg_len;
        logic [63:0] assoc;
        logic        assoc_on;
        logic [7:0]  data_byte;
    } t_item;

    // Configuration seen by the sequencer
    typedef struct packed {
        logic [127:0] key;
        logic [4:0]   tag_bytes;
        logic         decrypt;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_S0,
        ST_SHORT,
        ST_B0,
        ST_ADATA,
        ST_KS,
        ST_EMIT,
        ST_MAC,
        ST_TAG,
        ST_TAGIN,
        ST_STAT
    } t_state;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [10] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // SubBytes, ShiftRows and (unless final) MixColumns; byte 0 in the top bits
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic fin);
        logic [7:0]   t [16];
        logic [7:0]   a0, a1, a2, a3;
        logic [127:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[i + 4*c] = SBOX[s[127 - 8*(i + 4*((c + i) & 3)) -: 8]];
            end
        end
        if (!fin) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c];
                a1 = t[4*c + 1];
                a2 = t[4*c + 2];
                a3 = t[4*c + 3];
                t[4*c]     = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
                t[4*c + 1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
                t[4*c + 2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
                t[4*c + 3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
            end
        end
        for (int k = 0; k < 16; k++) begin
            r[127 - 8*k -: 8] = t[k];
        end
        return r;
    endfunction

    // One step of the AES-128 key schedule
    function automatic logic [127:0] key_step(input logic [127:0] rk, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, tmp, n0, n1, n2, n3;
        w0  = rk[127:96];
        w1  = rk[95:64];
        w2  = rk[63:32];
        w3  = rk[31:0];
        tmp = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        n0  = w0 ^ tmp;
        n1  = w1 ^ n0;
        n2  = w2 ^ n1;
        n3  = w3 ^ n2;
        return {n0, n1, n2, n3};
    endfunction

endpackage

// File: src/accm_aes_core.sv
`timescale 1ns / 1ps
// Iterative AES-128 encryption: one round and one key-schedule step per cycle.
module accm_aes_core
    import accm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [127:0] i_block,
    input  logic [127:0] i_key,
    output logic         o_busy,
    output logic         o_done,
    output logic [127:0] o_result
);

    logic [127:0] r_state, n_state;
    logic [127:0] r_rk, n_rk;
    logic [3:0]   r_round;
    logic         r_busy;
    logic         r_done;

    // Next round key and state
    always_comb begin
        n_rk    = key_step(r_rk, RCON[r_round - 4'd1]);
        n_state = aes_round(r_state, r_round == LAST_ROUND) ^ n_rk;
    end

    // Control; after a pass the round count parks on the last round until the next start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_round <= 4'd1;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_round <= 4'd1;
            end else if (r_busy) begin
                if (r_round == LAST_ROUND) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_round <= r_round + 4'd1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_state <= i_block ^ i_key;
            r_rk    <= i_key;
        end else if (r_busy) begin
            r_state <= n_state;
            r_rk    <= n_rk;
        end
    end

    assign o_busy   = r_busy;
    assign o_done   = r_done;
    assign o_result = r_state;

endmodule

// File: src/accm_front.sv
`timescale 1ns / 1ps
// Front end: takes requests, tags them and holds them in a two-entry queue.
module accm_front
    import accm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_kind,
    input  logic [143:0]  i_data,
    output logic          o_item_valid,
    output t_item         o_item,
    input  logic          i_pop
);

    t_item      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       w_push;
    t_item      w_item;

    // Classify and unpack the incoming request
    always_comb begin
        w_item.kind      = t_kind'(i_kind);
        w_item.nonce     = i_data[55:0];
        w_item.msg_len   = i_data[71:56];
        w_item.assoc     = i_data[135:72];
        w_item.assoc_on  = i_data[135:72] != 64'd0;
        w_item.data_byte = i_data[143:136];
    end

    assign o_ready      = r_count != 2'd2;
    assign w_push       = i_valid && o_ready;
    assign o_item_valid = r_count != 2'd0;
    assign o_item       = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= w_item;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) r_wptr <= ~r_wptr;
            if (i_pop)  r_rptr <= ~r_rptr;
            r_count <= r_count + {1'b0, w_push} - {1'b0, i_pop};
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue fill level out of range");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != 2'd0)
        else $error("pop from empty queue");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !i_pop) |=> r_count == $past(r_count) + 2'd1)
        else $error("queue level did not rise on push");

endmodule

// File: src/accm_back.sv
`timescale 1ns / 1ps
// Back end: CCM sequencer around a shared iterative AES core, with output register.
module accm_back
    import accm_pkg::*;
#(
    parameter int LENGTH_WIDTH = 16
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_item_valid,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output t_rkind      o_kind,
    output logic [7:0]  o_byte,
    output logic        o_ok,
    output logic        o_last
);

    localparam int LW = LENGTH_WIDTH;

    t_state         r_st, n_st;
    logic [127:0]   r_key, r_mac, r_s0, r_ks, r_buf, r_rtag;
    logic [55:0]    r_nonce;
    logic [63:0]    r_assoc;
    logic           r_assoc_on;
    logic [4:0]     r_tlen;
    logic           r_dec;
    logic [LW-1:0]  r_len, r_plain, r_pos, r_ctr;
    logic [7:0]     r_byte;
    logic           r_active;
    logic [3:0]     r_tidx;
    logic           r_launched;
    logic           r_out_valid;
    t_rkind         r_out_kind;
    logic [7:0]     r_out_byte;
    logic           r_out_ok;
    logic           r_out_last;

    logic           aes_start, aes_busy, aes_done;
    logic [127:0]   aes_in, aes_res;
    logic           w_aes_state, w_out_free, w_push;
    t_rkind         w_kind;
    logic [7:0]     w_byte;
    logic           w_ok, w_last;
    logic [4:0]     w_traw, w_tcl;
    logic [31:0]    w_len32;
    logic [LW-1:0]  w_len_m, w_pos1;
    logic [3:0]     w_off, w_tin_idx;
    logic [7:0]     w_ksb, w_res_byte, w_tag_byte;
    logic [63:0]    w_ctr64, w_plain64;
    logic [7:0]     w_b0_flags;
    logic           w_end_blk, w_msg_end, w_tag_ok;

    accm_aes_core u_aes (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (aes_start),
        .i_block  (aes_in),
        .i_key    (r_key),
        .o_busy   (aes_busy),
        .o_done   (aes_done),
        .o_result (aes_res)
    );

    // Start-time values: clamped tag length and masked length
    always_comb begin
        w_traw  = i_cfg.tag_bytes & 5'h1e;
        w_tcl   = (w_traw < TAG_MIN) ? TAG_MIN : ((w_traw > TAG_MAX) ? TAG_MAX : w_traw);
        w_len32 = {16'd0, i_item.msg_len};
        w_len_m = w_len32[LW-1:0];
    end

    // Per-byte values
    always_comb begin
        w_off      = r_pos[3:0];
        w_pos1     = r_pos + LW'(1);
        w_ksb      = r_ks[127 - 8*w_off -: 8];
        w_res_byte = r_byte ^ w_ksb;
        w_tag_byte = r_mac[127 - 8*r_tidx -: 8] ^ r_s0[127 - 8*r_tidx -: 8];
        w_tin_idx  = 4'(r_pos - r_plain);
        w_msg_end  = w_pos1 == r_plain;
        w_end_blk  = (w_off == BLOCK_LAST) || w_msg_end;
        w_ctr64    = {{(64-LW){1'b0}}, r_ctr};
        w_plain64  = {{(64-LW){1'b0}}, r_plain};
        w_b0_flags = (r_assoc_on ? ADATA_FLAG : 8'h00)
                     | {2'b00, 3'((r_tlen - 5'd2) >> 1), 3'b000} | CTR_FLAGS;
    end

    // Received tag check over the first t bytes
    always_comb begin
        w_tag_ok = 1'b1;
        for (int i = 0; i < 16; i++) begin
            if ((5'(i) < r_tlen) &&
                ((r_rtag[127 - 8*i -: 8] ^ r_s0[127 - 8*i -: 8]) != r_mac[127 - 8*i -: 8])) begin
                w_tag_ok = 1'b0;
            end
        end
    end

    // Next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: begin
                if (i_item_valid) begin
                    if (i_item.kind == KIND_START) begin
                        n_st = ST_S0;
                    end else if (r_active) begin
                        if (r_pos < r_plain) n_st = (w_off == 4'd0) ? ST_KS : ST_EMIT;
                        else                 n_st = ST_TAGIN;
                    end
                end
            end
            ST_S0: begin
                if (aes_done) begin
                    n_st = (r_dec && (32'(r_len) <= 32'(r_tlen))) ? ST_SHORT : ST_B0;
                end
            end
            ST_B0: begin
                if (aes_done) begin
                    if (r_assoc_on)              n_st = ST_ADATA;
                    else if (r_plain == LW'(0))  n_st = ST_TAG;
                    else                         n_st = ST_IDLE;
                end
            end
            ST_ADATA: begin
                if (aes_done) n_st = (r_plain == LW'(0)) ? ST_TAG : ST_IDLE;
            end
            ST_KS: begin
                if (aes_done) n_st = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_push) begin
                    if (w_end_blk)               n_st = ST_MAC;
                    else if (!r_dec && w_msg_end) n_st = ST_TAG;
                    else                         n_st = ST_IDLE;
                end
            end
            ST_MAC: begin
                if (aes_done) n_st = (!r_dec && r_pos == r_plain) ? ST_TAG : ST_IDLE;
            end
            ST_TAG: begin
                if (w_push && (5'(r_tidx) == r_tlen - 5'd1)) n_st = ST_IDLE;
            end
            ST_TAGIN: begin
                n_st = (w_pos1 == r_len) ? ST_STAT : ST_IDLE;
            end
            ST_SHORT, ST_STAT: begin
                if (w_push) n_st = ST_IDLE;
            end
            default: n_st = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: queue pop, AES launch, result push
    always_comb begin
        w_out_free  = !r_out_valid || i_ready;
        o_pop       = (r_st == ST_IDLE) && i_item_valid;
        w_aes_state = (r_st == ST_S0) || (r_st == ST_B0) || (r_st == ST_ADATA) ||
                      (r_st == ST_KS) || (r_st == ST_MAC);
        aes_start   = w_aes_state && !r_launched;
        case (r_st)
            ST_B0:    aes_in = {w_b0_flags, r_nonce, w_plain64};
            ST_ADATA: aes_in = r_mac ^ {8'h00, ADATA_LEN, r_assoc, 48'd0};
            ST_MAC:   aes_in = r_mac ^ r_buf;
            default:  aes_in = {CTR_FLAGS, r_nonce, w_ctr64};
        endcase
        w_push = w_out_free && ((r_st == ST_SHORT) || (r_st == ST_EMIT) ||
                                (r_st == ST_TAG) || (r_st == ST_STAT));
        w_kind = RK_STATUS;
        w_byte = 8'd0;
        w_ok   = 1'b0;
        w_last = 1'b1;
        case (r_st)
            ST_EMIT: begin
                w_kind = RK_DATA;
                w_byte = w_res_byte;
                w_last = 1'b0;
            end
            ST_TAG: begin
                w_kind = RK_TAG;
                w_byte = w_tag_byte;
                w_last = 5'(r_tidx) == r_tlen - 5'd1;
            end
            ST_STAT: w_ok = w_tag_ok;
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_active    <= 1'b0;
            r_launched  <= 1'b0;
            r_out_valid <= 1'b0;
            r_tidx      <= 4'd0;
            r_pos       <= '0;
            r_len       <= '0;
            r_plain     <= '0;
            r_ctr       <= '0;
        end else begin
            r_st <= n_st;
            if (aes_start)     r_launched <= 1'b1;
            else if (aes_done) r_launched <= 1'b0;
            if (w_push)        r_out_valid <= 1'b1;
            else if (i_ready)  r_out_valid <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    if (i_item_valid && i_item.kind == KIND_START) begin
                        r_active <= 1'b0;
                        r_len    <= w_len_m;
                        r_plain  <= i_cfg.decrypt ? w_len_m - LW'(w_tcl) : w_len_m;
                        r_pos    <= '0;
                        r_ctr    <= '0;
                        r_tidx   <= 4'd0;
                    end else if (i_item_valid && r_active && r_pos < r_plain &&
                                 w_off == 4'd0) begin
                        r_ctr <= r_ctr + LW'(1);
                    end
                end
                ST_B0: begin
                    if (aes_done && !r_assoc_on) r_active <= r_plain != LW'(0);
                end
                ST_ADATA: begin
                    if (aes_done) r_active <= r_plain != LW'(0);
                end
                ST_EMIT: begin
                    if (w_push) r_pos <= w_pos1;
                end
                ST_TAG: begin
                    if (w_push) begin
                        if (5'(r_tidx) == r_tlen - 5'd1) begin
                            r_tidx   <= 4'd0;
                            r_active <= 1'b0;
                        end else begin
                            r_tidx <= r_tidx + 4'd1;
                        end
                    end
                end
                ST_TAGIN: r_pos <= w_pos1;
                ST_STAT: begin
                    if (w_push) r_active <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out_kind <= w_kind;
            r_out_byte <= w_byte;
            r_out_ok   <= w_ok;
            r_out_last <= w_last;
        end
        case (r_st)
            ST_IDLE: begin
                if (i_item_valid && i_item.kind == KIND_START) begin
                    r_key      <= i_cfg.key;
                    r_dec      <= i_cfg.decrypt;
                    r_tlen     <= w_tcl;
                    r_nonce    <= i_item.nonce;
                    r_assoc    <= i_item.assoc;
                    r_assoc_on <= i_item.assoc_on;
                    r_buf      <= '0;
                    r_rtag     <= '0;
                end
                r_byte <= i_item.data_byte;
            end
            ST_S0:    if (aes_done) r_s0 <= aes_res;
            ST_B0:    if (aes_done) r_mac <= aes_res;
            ST_ADATA: if (aes_done) r_mac <= aes_res;
            ST_KS:    if (aes_done) r_ks <= aes_res;
            ST_EMIT: begin
                if (w_push) r_buf[127 - 8*w_off -: 8] <= r_dec ? w_res_byte : r_byte;
            end
            ST_MAC: begin
                if (aes_done) begin
                    r_mac <= aes_res;
                    r_buf <= '0;
                end
            end
            ST_TAGIN: r_rtag[127 - 8*w_tin_idx -: 8] <= r_byte;
            default: ;
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_kind  = r_out_kind;
    assign o_byte  = r_out_byte;
    assign o_ok    = r_out_ok;
    assign o_last  = r_out_last;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        aes_start |-> !aes_busy)
        else $error("AES launched while busy");

    a_open_msg_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_IDLE && r_active) |-> r_pos < r_len)
        else $error("open message past its length");

    a_tag_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_TAG) |-> 5'(r_tidx) < r_tlen)
        else $error("tag index beyond tag length");

endmodule

// File: src/aes_ccm_authenticated_cipher.sv
`timescale 1ns / 1ps
// Top level of the AES-128 CCM engine: config registers, front end and back end.
//
//  channel   | dir | handshake                | contents
//  s_axis    | in  | s_axis_tvalid/tready     | tuser kind; tdata nonce, length, assoc, byte
//  m_axis    | out | m_axis_tvalid/tready     | tuser result kind; tdata byte, tag_ok; tlast
//  cfg       | in  | i_cfg_we                 | i_cfg_addr register, i_cfg_wdata value
//
// A start request takes one AES pass for S0 and, unless a decrypt message is
// no longer than its tag, one for B0 and one more with associated data, in the
// shared iterative core. A data byte takes a keystream pass at a block's first
// byte and a MAC pass at its last; the next byte is popped once it is through.
// Tag bytes leave one a cycle while m_axis_tready is high. Reset is synchronous;
// the queue lets requests in while the result register waits on m_axis_tready.
module aes_ccm_authenticated_cipher
    import accm_pkg::*;
#(
    parameter int LENGTH_WIDTH = 16
)(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic          s_axis_tuser,   // kind
    input  logic [143:0]  s_axis_tdata,   // nonce[55:0], message_length, assoc_value, data_byte
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [1:0]    m_axis_tuser,   // result_kind
    output logic [15:0]   m_axis_tdata,   // out_byte, tag_ok, zero fill
    output logic          m_axis_tlast,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_addr,
    input  logic [63:0]   i_cfg_wdata
);

    logic [63:0] r_key_high, r_key_low;
    logic [4:0]  r_tag_bytes;
    logic        r_decrypt;
    t_cfg        w_cfg;
    t_item       w_item;
    logic        w_item_valid, w_pop;
    t_rkind      w_kind;
    logic [7:0]  w_byte;
    logic        w_ok;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high  <= 64'd0;
            r_key_low   <= 64'd0;
            r_tag_bytes <= TAG_MAX;
            r_decrypt   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_KEY_HIGH: r_key_high  <= i_cfg_wdata;
                CFG_KEY_LOW:  r_key_low   <= i_cfg_wdata;
                CFG_TAG_LEN:  r_tag_bytes <= i_cfg_wdata[4:0];
                CFG_DECRYPT:  r_decrypt   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign w_cfg = '{key: {r_key_high, r_key_low}, tag_bytes: r_tag_bytes, decrypt: r_decrypt};

    accm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_kind       (s_axis_tuser),
        .i_data       (s_axis_tdata),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_pop        (w_pop)
    );

    accm_back #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_pop        (w_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_kind       (w_kind),
        .o_byte       (w_byte),
        .o_ok         (w_ok),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tuser = w_kind;
    assign m_axis_tdata = {7'd0, w_ok, w_byte};

endmodule
